>>> sv/raster_to_pixel_block_tiler_macros.svh
// Assertion macros used by the checker file of the tiler.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef RASTER_TO_PIXEL_BLOCK_TILER_MACROS_SVH
`define RASTER_TO_PIXEL_BLOCK_TILER_MACROS_SVH

// same-cycle implication
`define RTPBT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTPBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rtpbt_pkg.sv
// Package of the raster to 4x4 block tiler: constants, register codes, queue types.
// No dependencies; used by every module of the tiler.
package rtpbt_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int BLOCK_SIDE    = 4;
	localparam int PIX_W         = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int WIDTH_REG_W   = 13;
	localparam int HEIGHT_REG_W  = 16;
	localparam int CMD_COL_W     = 14;
	localparam int CMDQ_DEPTH    = 2;
	localparam int OQ_DEPTH      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef enum logic {
		CMD_WRITE,
		CMD_BLOCK
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// row: line store row (write) or band row of the last row (block)
	// col: store column (write) or first column of the block (block)
	typedef struct packed {
		cmd_kind_t                     kind;
		logic [1:0]                    row;
		logic [CMD_COL_W-1:0]          col;
		logic [1:0]                    lastc;
		logic                          img_end;
		logic [BLOCK_SIDE-1:0][PIX_W-1:0] pix;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last_blk;
		logic             last_img;
	} out_t;

endpackage

>>> sv/rtpbt_front.sv
// Front of the tiler: size registers, raster counters, group collection.
// Turns pixels into line store writes and block commands. Uses rtpbt_pkg.
module rtpbt_front #(
	parameter int MAX_WIDTH = rtpbt_pkg::MAX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [rtpbt_pkg::PIX_W-1:0]          pixel_rgba,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rtpbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtpbt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 q_full,
	output logic                                 q_push,
	output rtpbt_pkg::cmd_t                      q_cmd
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int WW = (EW > rtpbt_pkg::WIDTH_REG_W) ? EW : rtpbt_pkg::WIDTH_REG_W;
	localparam int HW = rtpbt_pkg::HEIGHT_REG_W;

	logic [rtpbt_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [HW-1:0]                      height_q;
	logic [CW-1:0]                      col_q;
	logic [HW-1:0]                      row_q;
	logic [rtpbt_pkg::BLOCK_SIDE-1:0][rtpbt_pkg::PIX_W-1:0] grp_q;

	logic [WW-1:0] w_ext, eff_w;
	logic [HW-1:0] eff_h;
	logic          accept, cfg_wr, col_last, final_row, last_row, grp_done;
	logic [1:0]    band_row, sub;
	logic [rtpbt_pkg::BLOCK_SIDE-1:0][rtpbt_pkg::PIX_W-1:0] grp_merged;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign cfg_wr    = cfg_valid && (cfg_index == rtpbt_pkg::REG_IMAGE_WIDTH ||
		cfg_index == rtpbt_pkg::REG_IMAGE_HEIGHT);

	always_comb begin
		w_ext = WW'(width_q);
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = w_ext;
		end
		eff_h     = (height_q == '0) ? HW'(1) : height_q;
		col_last  = (WW'(col_q) + WW'(1)) == eff_w;
		final_row = ({1'b0, row_q} + (HW+1)'(1)) == {1'b0, eff_h};
		band_row  = row_q[1:0];
		last_row  = (band_row == 2'd3) || final_row;
		sub       = col_q[1:0];
		grp_done  = (sub == 2'd3) || col_last;
		grp_merged      = grp_q;
		grp_merged[sub] = pixel_rgba;
	end

	always_comb begin
		q_cmd         = '0;
		q_cmd.row     = band_row;
		q_cmd.img_end = final_row && col_last;
		q_cmd.lastc   = sub;
		if (!last_row) begin
			q_cmd.kind   = rtpbt_pkg::CMD_WRITE;
			q_cmd.col    = rtpbt_pkg::CMD_COL_W'(col_q);
			q_cmd.pix[0] = pixel_rgba;
		end else begin
			q_cmd.kind = rtpbt_pkg::CMD_BLOCK;
			q_cmd.col  = rtpbt_pkg::CMD_COL_W'(col_q & ~CW'(3));
			q_cmd.pix  = grp_merged;
		end
		q_push = accept && (!last_row || grp_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rtpbt_pkg::WIDTH_REG_W'(1);
			height_q <= HW'(1);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == rtpbt_pkg::REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[rtpbt_pkg::WIDTH_REG_W-1:0];
			end else begin
				height_q <= cfg_data[HW-1:0];
			end
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= final_row ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_row) begin
			grp_q[sub] <= pixel_rgba;
		end
	end

endmodule

>>> sv/rtpbt_cmdq.sv
// Short command queue between the front and the back of the tiler.
// Register-based FIFO of rtpbt_pkg::cmd_t entries. Uses rtpbt_pkg.
module rtpbt_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  rtpbt_pkg::cmd_t wr_cmd,
	output logic            q_full,
	input  logic            rd,
	output logic            q_valid,
	output rtpbt_pkg::cmd_t rd_cmd
);
	localparam int PW = $clog2(rtpbt_pkg::CMDQ_DEPTH);
	localparam int NW = $clog2(rtpbt_pkg::CMDQ_DEPTH + 1);

	rtpbt_pkg::cmd_t ent_q [rtpbt_pkg::CMDQ_DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [NW-1:0]   cnt_q;
	logic            do_wr, do_rd;

	assign q_full  = cnt_q == NW'(rtpbt_pkg::CMDQ_DEPTH);
	assign q_valid = cnt_q != '0;
	assign rd_cmd  = ent_q[rptr_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(rtpbt_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(rtpbt_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(do_wr) - NW'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

>>> sv/rtpbt_back.sv
// Back of the tiler: line store memory, block read-out sequencer, result FIFO.
// Executes rtpbt_pkg::cmd_t entries in order. Uses rtpbt_pkg.
module rtpbt_back #(
	parameter int MAX_WIDTH = rtpbt_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  rtpbt_pkg::cmd_t             q_cmd,
	output logic                        q_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [rtpbt_pkg::PIX_W-1:0] block_pixel,
	output logic                        last_of_block,
	output logic                        last_of_image
);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int AW    = CW + 2;
	localparam int DEPTH = 3 * (2 ** CW);
	localparam int OPW   = $clog2(rtpbt_pkg::OQ_DEPTH);
	localparam int ONW   = $clog2(rtpbt_pkg::OQ_DEPTH + 1);

	logic [rtpbt_pkg::PIX_W-1:0] mem [DEPTH];

	rtpbt_pkg::back_state_t state_q, state_d;
	rtpbt_pkg::cmd_t        cur_q;
	logic [3:0]             n_q;

	logic                        valid_s1, use_mem_s1, lb_s1, li_s1;
	logic [rtpbt_pkg::PIX_W-1:0] rd_s1, grp_s1;

	rtpbt_pkg::out_t oq_q [rtpbt_pkg::OQ_DEPTH];
	logic [OPW-1:0]  owp_q, orp_q;
	logic [ONW-1:0]  ocnt_q;

	logic          mem_we, load, issue, room, o_rd, use_mem, n_end;
	logic [1:0]    r, c, sc;
	logic [AW-1:0] waddr, raddr;
	rtpbt_pkg::out_t o_new;

	assign r       = n_q[3:2];
	assign c       = n_q[1:0];
	assign sc      = (c < cur_q.lastc) ? c : cur_q.lastc;
	assign use_mem = r < cur_q.row;
	assign raddr   = {r, cur_q.col[CW-1:0] | CW'(sc)};
	assign waddr   = {q_cmd.row, q_cmd.col[CW-1:0]};
	assign n_end   = n_q == 4'd15;
	assign room    = (ocnt_q + ONW'(valid_s1)) < ONW'(rtpbt_pkg::OQ_DEPTH);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		mem_we  = 1'b0;
		load    = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			rtpbt_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd.kind == rtpbt_pkg::CMD_WRITE) begin
						mem_we = 1'b1;
					end else begin
						load    = 1'b1;
						state_d = rtpbt_pkg::BK_EMIT;
					end
				end
			end
			rtpbt_pkg::BK_EMIT: begin
				if (room) begin
					issue = 1'b1;
					if (n_end) begin
						state_d = rtpbt_pkg::BK_IDLE;
					end
				end
			end
			default: state_d = rtpbt_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rtpbt_pkg::BK_IDLE;
			n_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (load) begin
				n_q <= '0;
			end else if (issue) begin
				n_q <= n_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_cmd;
		end
		if (issue) begin
			use_mem_s1 <= use_mem;
			grp_s1     <= cur_q.pix[sc];
			lb_s1      <= n_end;
			li_s1      <= n_end && cur_q.img_end;
		end
	end

	// line store: written in idle, read while emitting rows held in the store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= q_cmd.pix[0];
		end
		if (issue && use_mem) begin
			rd_s1 <= mem[raddr];
		end
	end

	// result FIFO
	assign o_new.pixel    = use_mem_s1 ? rd_s1 : grp_s1;
	assign o_new.last_blk = lb_s1;
	assign o_new.last_img = li_s1;
	assign empty          = ocnt_q == '0;
	assign o_rd           = pop && !empty;
	assign block_pixel    = oq_q[orp_q].pixel;
	assign last_of_block  = oq_q[orp_q].last_blk;
	assign last_of_image  = oq_q[orp_q].last_img;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s1) begin
				owp_q <= (owp_q == OPW'(rtpbt_pkg::OQ_DEPTH - 1)) ? '0 : owp_q + OPW'(1);
			end
			if (o_rd) begin
				orp_q <= (orp_q == OPW'(rtpbt_pkg::OQ_DEPTH - 1)) ? '0 : orp_q + OPW'(1);
			end
			ocnt_q <= ocnt_q + ONW'(valid_s1) - ONW'(o_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[owp_q] <= o_new;
		end
	end

endmodule

>>> sv/raster_to_pixel_block_tiler.sv
// Top level of the raster to 4x4 block tiler with edge replication.
// Instantiates rtpbt_front, rtpbt_cmdq and rtpbt_back; uses rtpbt_pkg.
//
// Usage:
//   Input queue (push/full/pixel_rgba): RGBA pixels of one image in raster order.
//   Result queue (empty/pop): 4x4 blocks, row-major, 16 items per block;
//   last_of_block marks each block's 16th item, last_of_image the image's last.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
//   width (13 bits), index 1 the height (16 bits); either write restarts the
//   image. cfg_ready is always high; write only while the block is idle.
// Timing:
//   Pixels of the first rows of a band go to the line store at one per cycle
//   while the command queue has room. A pixel completing a group of four, or
//   the row's last pixel, in a band's last row releases a block: 16 results
//   at one per cycle while the result FIFO has room. The back takes the command,
//   then emits the block, taking no other command meanwhile; a two-entry
//   command queue decouples input from read-out.
// Reset: clears counters and queues, sets width and height to 1.
// Stall: when pop stays low the 4-entry result FIFO fills, read-out pauses,
//   then the command queue fills and full rises.
module raster_to_pixel_block_tiler #(
	parameter int MAX_WIDTH = rtpbt_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [rtpbt_pkg::PIX_W-1:0]      pixel_rgba,
	output logic                             empty,
	input  logic                             pop,
	output logic [rtpbt_pkg::PIX_W-1:0]      block_pixel,
	output logic                             last_of_block,
	output logic                             last_of_image,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rtpbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtpbt_pkg::CFG_DATA_W-1:0] cfg_data
);
	logic            q_full, q_push, q_valid, q_pop;
	rtpbt_pkg::cmd_t q_wcmd, q_rcmd;

	rtpbt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pixel_rgba (pixel_rgba),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_wcmd)
	);

	rtpbt_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_cmd  (q_wcmd),
		.q_full  (q_full),
		.rd      (q_pop),
		.q_valid (q_valid),
		.rd_cmd  (q_rcmd)
	);

	rtpbt_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cmd         (q_rcmd),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.block_pixel   (block_pixel),
		.last_of_block (last_of_block),
		.last_of_image (last_of_image)
	);

endmodule

>>> sv/rtpbt_checker.sv
// Port-level checker of the tiler, bound to raster_to_pixel_block_tiler.
// Depends on raster_to_pixel_block_tiler_macros.svh and rtpbt_pkg.
`include "raster_to_pixel_block_tiler_macros.svh"

module rtpbt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [rtpbt_pkg::PIX_W-1:0] block_pixel,
	input logic                        last_of_block,
	input logic                        last_of_image
);
	logic [3:0] cnt_q;
	logic       taken;

	assign taken = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (taken) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	`RTPBT_ASSERT_NOW(a_blk_len, taken, last_of_block == (cnt_q == 4'd15), "block not 16 items")
	`RTPBT_ASSERT_NOW(a_img_end, !empty && last_of_image, last_of_block, "image end off block end")
	`RTPBT_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(block_pixel), "stalled item lost")

endmodule

bind raster_to_pixel_block_tiler rtpbt_checker u_rtpbt_checker (.*);
